// ===== src/two_colour_tile_image_decoder_defines.svh =====
// Assertion macros shared by the checker of the two-colour tile image decoder.
`ifndef TWO_COLOUR_TILE_IMAGE_DECODER_DEFINES_SVH
`define TWO_COLOUR_TILE_IMAGE_DECODER_DEFINES_SVH

// Check that a condition implies another one in the same cycle.
`define TCD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tcd checker: same-cycle property failed");

// Check that a condition implies another one in the next cycle.
`define TCD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tcd checker: next-cycle property failed");

`endif

// ===== src/tcd_pkg.sv =====
// Types and constants of the two-colour tile image decoder.
`default_nettype none
package tcd_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int RGB_W       = 24;
  localparam int MAX_DEPTH   = 8;

  // Header byte positions
  localparam logic [2:0] HDR_ACROSS_LO = 3'd0;
  localparam logic [2:0] HDR_ACROSS_HI = 3'd1;
  localparam logic [2:0] HDR_DOWN_LO   = 3'd2;
  localparam logic [2:0] HDR_DOWN_HI   = 3'd3;
  localparam logic [2:0] HDR_DEPTH_LO  = 3'd4;
  localparam logic [2:0] HDR_LAST      = 3'd5;

  // Palette component positions
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  // Tile byte positions
  localparam logic [1:0] TB_COLOUR1 = 2'd0;
  localparam logic [1:0] TB_COLOUR0 = 2'd1;
  localparam logic [1:0] TB_MAP_LO  = 2'd2;
  localparam logic [1:0] TB_MAP_HI  = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_TILES,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } in_item_t;

  typedef struct packed {
    logic [17:0] pixel_x;
    logic [17:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        tile_last;
    logic        image_last;
  } out_item_t;

  // One decoded tile waiting for pixel output
  typedef struct packed {
    logic [7:0]  colour1;
    logic [7:0]  colour0;
    logic [15:0] map;
    logic [15:0] col;
    logic [15:0] row;
    logic        final_tile;
  } tile_desc_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [RGB_W-1:0]  data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr1;
    logic [PAL_AW-1:0] addr0;
  } pal_rd_t;

endpackage
`default_nettype wire

// ===== src/two_colour_tile_image_decoder.sv =====
// Top level of the two-colour tile image decoder.
// Decodes a chunk byte stream (6-byte header, 2^depth RGB palette entries, then
// 4-byte tiles) into 16 pixel transactions per tile, one pixel per cycle while
// out_stall is low. A tile's first pixel appears after the tile descriptor
// register and then the emitter and palette read registers when the emitter is
// free. One decoded tile can wait while the previous one is emitted, so header,
// palette and tile bytes are taken at up to one per cycle; while a decoded tile
// waits, in_stall is high. Sustained rate during the tile section is set by the
// emitter, which takes a new tile only as the last pixel of the previous one is
// accepted. The palette memory needs no clearing pass: per-entry valid bits are
// cleared by reset and an unwritten entry reads as black.
`default_nettype none
module two_colour_tile_image_decoder
  import tcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  pal_wr_t          pal_wr;
  pal_rd_t          pal_rd;
  tile_desc_t       desc;
  logic             desc_valid;
  logic             desc_take;
  logic [RGB_W-1:0] rgb1;
  logic [RGB_W-1:0] rgb0;

  tcd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .pal_wr     (pal_wr),
    .desc       (desc),
    .desc_valid (desc_valid),
    .desc_take  (desc_take)
  );

  tcd_palette u_palette (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (pal_wr),
    .rd    (pal_rd),
    .rgb1  (rgb1),
    .rgb0  (rgb0)
  );

  tcd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (desc),
    .desc_valid (desc_valid),
    .desc_take  (desc_take),
    .pal_rd     (pal_rd),
    .rgb1       (rgb1),
    .rgb0       (rgb0),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== src/tcd_palette.sv =====
// Palette memory: one write port, two registered read ports, per-entry valid bits.
`default_nettype none
module tcd_palette
  import tcd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pal_wr_t          wr,
  input  wire pal_rd_t          rd,
  output logic [RGB_W-1:0]      rgb1,
  output logic [RGB_W-1:0]      rgb0
);

  logic [RGB_W-1:0]       mem [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] vld_r;
  logic [RGB_W-1:0]       d1_r;
  logic [RGB_W-1:0]       d0_r;
  logic                   v1_r;
  logic                   v0_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Read both colours; hold data until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      d1_r <= mem[rd.addr1];
      d0_r <= mem[rd.addr0];
      v1_r <= vld_r[rd.addr1];
      v0_r <= vld_r[rd.addr0];
    end
  end

  assign rgb1 = v1_r ? d1_r : '0;
  assign rgb0 = v0_r ? d0_r : '0;

endmodule
`default_nettype wire

// ===== src/tcd_parse.sv =====
// Byte stream parser: header, palette load and tile collection.
`default_nettype none
module tcd_parse
  import tcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output pal_wr_t       pal_wr,
  output tile_desc_t    desc,
  output logic          desc_valid,
  input  wire logic     desc_take
);

  phase_t      phase_r, phase_nxt, ph;
  logic [7:0]  cnt_r, cnt_nxt, cnt;
  logic [1:0]  comp_r, comp_nxt;
  logic [15:0] across_r, across_nxt;
  logic [15:0] down_r, down_nxt;
  logic [3:0]  depth_r, depth_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] part_r, part_nxt;
  logic [7:0]  c1_r, c1_nxt;
  logic [7:0]  c0_r, c0_nxt;
  logic [7:0]  maplo_r, maplo_nxt;
  tile_desc_t  desc_r, desc_nxt;
  logic        desc_vld_r;
  logic        acc;
  logic        tile_done;
  logic        final_tile;
  logic [7:0]  b;
  logic [7:0]  last_idx;
  logic [15:0] col_inc;

  assign in_stall   = desc_vld_r && !desc_take;
  assign acc        = in_valid && !in_stall;
  assign b          = in_data.data_byte;
  assign ph         = in_data.chunk_start ? PH_HEADER : phase_r;
  assign cnt        = in_data.chunk_start ? 8'd0 : cnt_r;
  assign last_idx   = 8'((9'd1 << depth_r) - 9'd1);
  assign col_inc    = col_r + 16'd1;
  assign final_tile = ({1'b0, col_r} + 17'd1 == {1'b0, across_r}) &&
                      ({1'b0, row_r} + 17'd1 == {1'b0, down_r});
  assign tile_done  = acc && (ph == PH_TILES) && (cnt[1:0] == TB_MAP_HI);

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      phase_nxt = ph;
      unique case (ph)
        PH_HEADER: begin
          if (cnt[2:0] == HDR_LAST) begin
            phase_nxt = PH_PALETTE;
          end
        end
        PH_PALETTE: begin
          if (comp_r == COMP_BLUE && cnt == last_idx) begin
            phase_nxt = (across_r == '0 || down_r == '0) ? PH_DONE : PH_TILES;
          end
        end
        PH_TILES: begin
          if (tile_done && final_tile) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Datapath and outputs for the accepted byte
  always_comb begin
    cnt_nxt    = cnt_r;
    comp_nxt   = comp_r;
    across_nxt = across_r;
    down_nxt   = down_r;
    depth_nxt  = depth_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    part_nxt   = part_r;
    c1_nxt     = c1_r;
    c0_nxt     = c0_r;
    maplo_nxt  = maplo_r;
    desc_nxt   = desc_r;
    pal_wr     = '0;
    if (acc) begin
      cnt_nxt = cnt;
      unique case (ph)
        PH_HEADER: begin
          case (cnt[2:0])
            HDR_ACROSS_LO: across_nxt = {8'd0, b};
            HDR_ACROSS_HI: across_nxt = {b, across_r[7:0]};
            HDR_DOWN_LO:   down_nxt   = {8'd0, b};
            HDR_DOWN_HI:   down_nxt   = {b, down_r[7:0]};
            HDR_DEPTH_LO:  depth_nxt  = (b > 8'(MAX_DEPTH)) ? 4'(MAX_DEPTH) : b[3:0];
            default: begin
              if (b != 8'd0) begin
                depth_nxt = 4'(MAX_DEPTH);
              end
            end
          endcase
          if (cnt[2:0] == HDR_LAST) begin
            cnt_nxt  = '0;
            comp_nxt = COMP_RED;
            col_nxt  = '0;
            row_nxt  = '0;
          end else begin
            cnt_nxt = cnt + 8'd1;
          end
        end
        PH_PALETTE: begin
          case (comp_r)
            COMP_RED:   part_nxt = {8'd0, b};
            COMP_GREEN: part_nxt = {b, part_r[7:0]};
            default: begin
              pal_wr.en   = 1'b1;
              pal_wr.addr = cnt;
              pal_wr.data = {b, part_r};
            end
          endcase
          if (comp_r == COMP_BLUE) begin
            comp_nxt = COMP_RED;
            cnt_nxt  = (cnt == last_idx) ? 8'd0 : cnt + 8'd1;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
        PH_TILES: begin
          cnt_nxt = {6'd0, cnt[1:0] + 2'd1};
          case (cnt[1:0])
            TB_COLOUR1: c1_nxt    = b;
            TB_COLOUR0: c0_nxt    = b;
            TB_MAP_LO:  maplo_nxt = b;
            default: begin
              desc_nxt.colour1    = c1_r;
              desc_nxt.colour0    = c0_r;
              desc_nxt.map        = {b, maplo_r};
              desc_nxt.col        = col_r;
              desc_nxt.row        = row_r;
              desc_nxt.final_tile = final_tile;
              if (!final_tile) begin
                if (col_inc == across_r) begin
                  col_nxt = '0;
                  row_nxt = row_r + 16'd1;
                end else begin
                  col_nxt = col_inc;
                end
              end
            end
          endcase
        end
        default: begin
          cnt_nxt = cnt;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      cnt_r      <= '0;
      comp_r     <= COMP_RED;
      across_r   <= '0;
      down_r     <= '0;
      depth_r    <= '0;
      col_r      <= '0;
      row_r      <= '0;
      desc_vld_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      comp_r   <= comp_nxt;
      across_r <= across_nxt;
      down_r   <= down_nxt;
      depth_r  <= depth_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      if (tile_done) begin
        desc_vld_r <= 1'b1;
      end else if (desc_take) begin
        desc_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    part_r  <= part_nxt;
    c1_r    <= c1_nxt;
    c0_r    <= c0_nxt;
    maplo_r <= maplo_nxt;
    desc_r  <= desc_nxt;
  end

  assign desc       = desc_r;
  assign desc_valid = desc_vld_r;

endmodule
`default_nettype wire

// ===== src/tcd_emit.sv =====
// Pixel emitter: expands one tile into sixteen pixel transactions.
`default_nettype none
module tcd_emit
  import tcd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tile_desc_t       desc,
  input  wire logic             desc_valid,
  output logic                  desc_take,
  output pal_rd_t               pal_rd,
  input  wire logic [RGB_W-1:0] rgb1,
  input  wire logic [RGB_W-1:0] rgb0,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  logic        active_r;
  logic [3:0]  pix_r;
  logic [15:0] map_r;
  logic [15:0] col_r;
  logic [15:0] row_r;
  logic        final_r;
  logic        out_acc;
  logic        last_pix;
  logic [RGB_W-1:0] rgb;

  assign out_acc   = active_r && !out_stall;
  assign last_pix  = pix_r == 4'd15;
  assign desc_take = desc_valid && (!active_r || (out_acc && last_pix));

  // Read both palette entries as the tile is taken
  always_comb begin
    pal_rd.en    = desc_take;
    pal_rd.addr1 = desc.colour1;
    pal_rd.addr0 = desc.colour0;
  end

  // Pixel sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pix_r    <= '0;
    end else if (desc_take) begin
      active_r <= 1'b1;
      pix_r    <= '0;
    end else if (out_acc) begin
      pix_r <= pix_r + 4'd1;
      if (last_pix) begin
        active_r <= 1'b0;
      end
    end
  end

  // Hold tile fields for the whole tile
  always_ff @(posedge clk) begin
    if (desc_take) begin
      map_r   <= desc.map;
      col_r   <= desc.col;
      row_r   <= desc.row;
      final_r <= desc.final_tile;
    end
  end

  // Map bit 15 drives pixel 0
  assign rgb = map_r[~pix_r] ? rgb1 : rgb0;

  always_comb begin
    out_data.pixel_x    = {col_r, pix_r[1:0]};
    out_data.pixel_y    = {row_r, pix_r[3:2]};
    out_data.red        = rgb[7:0];
    out_data.green      = rgb[15:8];
    out_data.blue       = rgb[23:16];
    out_data.tile_last  = last_pix;
    out_data.image_last = last_pix && final_r;
  end

  assign out_valid = active_r;

endmodule
`default_nettype wire

// ===== src/tcd_checker.sv =====
// Port-level checker of the decoder and its bind to the top level.
`default_nettype none
`include "two_colour_tile_image_decoder_defines.svh"
module tcd_checker
  import tcd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled pixel holds
  `TCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // The image ends only on a tile end
  `TCD_ASSERT_NOW(a_image_on_tile, out_valid && out_data.image_last, out_data.tile_last)

  // A tile ends on its bottom-right pixel
  `TCD_ASSERT_NOW(a_tile_corner, out_valid && out_data.tile_last, out_data.pixel_x[1:0] == 2'd3 && out_data.pixel_y[1:0] == 2'd3)

  // Pixels of a tile follow without gaps
  `TCD_ASSERT_NEXT(a_tile_gapless, out_valid && !out_stall && !out_data.tile_last, out_valid)

endmodule

bind two_colour_tile_image_decoder tcd_checker u_tcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
